// File: rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and per-byte decode functions of the UTF-8 to
// UTF-16 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  // configuration register indexes
  localparam logic CFG_FATAL_MODE = 1'b0;
  localparam logic CFG_KEEP_BOM   = 1'b1;

  localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
  localparam logic [20:0] BOM_CODE_POINT   = 21'h00FEFF;
  localparam logic [20:0] SUPP_FIRST       = 21'h010000;
  localparam logic [20:0] SUPP_LAST        = 21'h10FFFF;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
  localparam logic [7:0]  CONT_LOW         = 8'h80;
  localparam logic [7:0]  CONT_HIGH        = 8'hBF;

  localparam int RESULT_FIFO_DEPTH = 4;
  localparam int RESULT_PTR_W      = $clog2(RESULT_FIFO_DEPTH);

  typedef enum logic [1:0] {
    RC_OK,
    RC_ERR,
    RC_RETRY
  } u8d_rc_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        decode_error;
    logic        stream_end;
  } u8d_result_t;

  typedef struct packed {
    logic [20:0] partial_code;
    logic [1:0]  bytes_needed;
    logic [1:0]  bytes_seen;
    logic [7:0]  next_lower_limit;
    logic [7:0]  next_upper_limit;
    logic        at_stream_start;
    logic        skipping_to_end;
  } u8d_state_t;

  typedef struct packed {
    u8d_state_t           st;
    u8d_result_t [1:0]    res;
    logic [1:0]           count;
    u8d_rc_t              rc;
    logic                 aborted;
  } u8d_ctx_t;

  localparam u8d_state_t STATE_RESET = '{
    partial_code:     21'd0,
    bytes_needed:     2'd0,
    bytes_seen:       2'd0,
    next_lower_limit: CONT_LOW,
    next_upper_limit: CONT_HIGH,
    at_stream_start:  1'b1,
    skipping_to_end:  1'b0
  };

  function automatic u8d_ctx_t clear_seq(input u8d_ctx_t c);
    u8d_ctx_t r;
    r = c;
    r.st.partial_code     = '0;
    r.st.bytes_needed     = '0;
    r.st.bytes_seen       = '0;
    r.st.next_lower_limit = CONT_LOW;
    r.st.next_upper_limit = CONT_HIGH;
    return r;
  endfunction

  // results beyond two are dropped
  function automatic u8d_ctx_t put(input u8d_ctx_t c, input logic [15:0] unit,
                                   input logic has, input logic err);
    u8d_ctx_t r;
    r = c;
    if (r.count < 2'd2) begin
      r.res[r.count[0]].code_unit    = unit;
      r.res[r.count[0]].has_unit     = has;
      r.res[r.count[0]].decode_error = err;
      r.res[r.count[0]].stream_end   = 1'b0;
      r.count = r.count + 2'd1;
    end
    return r;
  endfunction

  function automatic u8d_ctx_t emit_cp(input u8d_ctx_t c, input logic [20:0] cp,
                                       input logic keep_bom);
    u8d_ctx_t    r;
    logic [20:0] v;
    r = c;
    v = cp - SUPP_FIRST;
    if (r.st.at_stream_start && (cp == BOM_CODE_POINT) && !keep_bom) begin
      r.st.at_stream_start = 1'b0;
    end else begin
      r.st.at_stream_start = 1'b0;
      if ((cp >= SUPP_FIRST) && (cp <= SUPP_LAST)) begin
        r = put(r, HIGH_SURR_BASE | {6'd0, v[19:10]}, 1'b1, 1'b0);
        r = put(r, LOW_SURR_BASE | {6'd0, v[9:0]}, 1'b1, 1'b0);
      end else begin
        r = put(r, cp[15:0], 1'b1, 1'b0);
      end
    end
    return r;
  endfunction

  function automatic u8d_ctx_t take_byte(input u8d_ctx_t c, input logic [7:0] b,
                                         input logic keep_bom);
    u8d_ctx_t    r;
    logic [20:0] cp;
    r    = c;
    r.rc = RC_OK;
    cp   = '0;
    if (r.st.bytes_needed == 2'd0) begin
      if (b < 8'h80) begin
        r = emit_cp(r, {13'd0, b}, keep_bom);
      end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
        r.st.bytes_needed = 2'd1;
        r.st.partial_code = {16'd0, b[4:0]};
      end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
        if (b == 8'hE0) r.st.next_lower_limit = 8'hA0;
        if (b == 8'hED) r.st.next_upper_limit = 8'h9F;
        r.st.bytes_needed = 2'd2;
        r.st.partial_code = {17'd0, b[3:0]};
      end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
        if (b == 8'hF0) r.st.next_lower_limit = 8'h90;
        if (b == 8'hF4) r.st.next_upper_limit = 8'h8F;
        r.st.bytes_needed = 2'd3;
        r.st.partial_code = {18'd0, b[2:0]};
      end else begin
        r.rc = RC_ERR;
      end
    end else if ((b < r.st.next_lower_limit) || (b > r.st.next_upper_limit)) begin
      r    = clear_seq(r);
      r.rc = RC_RETRY;
    end else begin
      r.st.next_lower_limit = CONT_LOW;
      r.st.next_upper_limit = CONT_HIGH;
      r.st.partial_code     = {r.st.partial_code[14:0], b[5:0]};
      r.st.bytes_seen       = r.st.bytes_seen + 2'd1;
      if (r.st.bytes_seen == r.st.bytes_needed) begin
        cp = r.st.partial_code;
        r  = clear_seq(r);
        r  = emit_cp(r, cp, keep_bom);
      end
    end
    return r;
  endfunction

  // mark the final result, adding an end marker when nothing came out
  function automatic u8d_ctx_t finish_stream(input u8d_ctx_t c);
    u8d_ctx_t r;
    r = c;
    if (r.count == 2'd0) r = put(r, 16'd0, 1'b0, 1'b0);
    if (r.count == 2'd1) r.res[0].stream_end = 1'b1;
    else                 r.res[1].stream_end = 1'b1;
    r = clear_seq(r);
    r.st.at_stream_start = 1'b1;
    r.st.skipping_to_end = 1'b0;
    return r;
  endfunction

  function automatic u8d_ctx_t report_error(input u8d_ctx_t c, input logic last,
                                            input logic fatal_mode,
                                            input logic keep_bom);
    u8d_ctx_t r;
    r = c;
    if (fatal_mode) begin
      r = put(r, 16'd0, 1'b0, 1'b1);
      r = clear_seq(r);
      if (last) r = finish_stream(r);
      else      r.st.skipping_to_end = 1'b1;
      r.aborted = 1'b1;
    end else begin
      r = emit_cp(r, {5'd0, REPLACEMENT_CHAR}, keep_bom);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// Streaming UTF-8 to UTF-16 decoder with replacement, fatal and BOM handling.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    byte_value, last_byte
//   out      source     out_valid / out_ready  code_unit, has_unit,
//                                              decode_error, stream_end
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte is held in the input register, decoded and pushed into a four-entry
// result queue; a new byte can enter every cycle while the queue has room.
// Each byte gives zero to two results; the queue drains one per cycle while
// out_ready is high, so a byte that makes a surrogate pair needs two pops.
// The input register holds while the queue has fewer than two free entries.
// Reset clears the decoder state and both configuration registers; cfg_ready
// is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [7:0]   byte_value,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] code_unit,
  output logic        has_unit,
  output logic        decode_error,
  output logic        stream_end,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire         cfg_data
);

  localparam int PtrW = u8d_pkg::RESULT_PTR_W;

  logic                   fatal_mode;
  logic                   keep_bom;
  u8d_pkg::u8d_state_t    st;
  logic                   in_q_valid;
  logic [7:0]             in_q_byte;
  logic                   in_q_last;
  u8d_pkg::u8d_ctx_t      ctx;
  logic                   commit;
  logic                   pop;
  u8d_pkg::u8d_result_t   fifo [u8d_pkg::RESULT_FIFO_DEPTH];
  logic [PtrW-1:0]        wr_ptr;
  logic [PtrW-1:0]        rd_ptr;
  logic [PtrW:0]          fill;
  logic [PtrW:0]          fill_next;
  logic [PtrW-1:0]        wr_ptr_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fatal_mode <= 1'b0;
      keep_bom   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        u8d_pkg::CFG_FATAL_MODE: fatal_mode <= cfg_data;
        u8d_pkg::CFG_KEEP_BOM:   keep_bom   <= cfg_data;
        default: ;
      endcase
    end
  end

  // room for the worst case of two results
  assign commit   = in_q_valid &&
                    (fill <= (PtrW+1)'(u8d_pkg::RESULT_FIFO_DEPTH - 2));
  assign in_ready = !in_q_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= byte_value;
      in_q_last <= last_byte;
    end
  end

  u8d_step u_step (
    .st         (st),
    .byte_value (in_q_byte),
    .last_byte  (in_q_last),
    .fatal_mode (fatal_mode),
    .keep_bom   (keep_bom),
    .ctx        (ctx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= u8d_pkg::STATE_RESET;
    end else if (commit) begin
      st <= ctx.st;
    end
  end

  // result queue
  assign pop        = out_valid && out_ready;
  assign wr_ptr_inc = wr_ptr + PtrW'(1);

  always_comb begin
    fill_next = fill;
    if (commit) fill_next = fill_next + (PtrW+1)'(ctx.count);
    if (pop)    fill_next = fill_next - (PtrW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (commit) wr_ptr <= wr_ptr + PtrW'(ctx.count);
      if (pop)    rd_ptr <= rd_ptr + PtrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (ctx.count != 2'd0) fifo[wr_ptr]     <= ctx.res[0];
      if (ctx.count == 2'd2) fifo[wr_ptr_inc] <= ctx.res[1];
    end
  end

  assign out_valid    = (fill != '0);
  assign code_unit    = fifo[rd_ptr].code_unit;
  assign has_unit     = fifo[rd_ptr].has_unit;
  assign decode_error = fifo[rd_ptr].decode_error;
  assign stream_end   = fifo[rd_ptr].stream_end;

endmodule

`default_nettype wire

// File: rtl/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step
// Combinational decode of one byte: next decoder state and up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_step (
  input  wire u8d_pkg::u8d_state_t st,
  input  wire logic [7:0]          byte_value,
  input  wire logic                last_byte,
  input  wire logic                fatal_mode,
  input  wire logic                keep_bom,
  output u8d_pkg::u8d_ctx_t        ctx
);

  always_comb begin
    ctx         = '0;
    ctx.st      = st;
    ctx.rc      = u8d_pkg::RC_OK;
    ctx.aborted = 1'b0;
    if (st.skipping_to_end) begin
      // aborted stream: swallow bytes until the last one
      if (last_byte) ctx = u8d_pkg::finish_stream(ctx);
    end else begin
      ctx = u8d_pkg::take_byte(ctx, byte_value, keep_bom);
      if (ctx.rc != u8d_pkg::RC_OK) begin
        if (ctx.rc == u8d_pkg::RC_RETRY) begin
          ctx = u8d_pkg::report_error(ctx, last_byte, fatal_mode, keep_bom);
          if (!ctx.aborted) begin
            // bad continuation byte gets a second look as a leader
            ctx = u8d_pkg::take_byte(ctx, byte_value, keep_bom);
            if (ctx.rc != u8d_pkg::RC_OK)
              ctx = u8d_pkg::report_error(ctx, last_byte, fatal_mode, keep_bom);
          end
        end else begin
          ctx = u8d_pkg::report_error(ctx, last_byte, fatal_mode, keep_bom);
        end
      end
      if (!ctx.aborted && last_byte) begin
        if (ctx.st.bytes_needed != 2'd0) begin
          // truncated sequence at end of stream
          ctx = u8d_pkg::clear_seq(ctx);
          ctx = u8d_pkg::report_error(ctx, last_byte, fatal_mode, keep_bom);
        end
        if (!ctx.aborted) ctx = u8d_pkg::finish_stream(ctx);
      end
    end
  end

endmodule

`default_nettype wire
